FILE: sv/ewma_zscore_normalizer_top_macros.svh
// Assertion macros for the EWMA z-score normalizer checker.
// No dependencies; included by the checker file.
`ifndef EWMA_ZSCORE_NORMALIZER_TOP_MACROS_SVH
`define EWMA_ZSCORE_NORMALIZER_TOP_MACROS_SVH

// same-cycle implication
`define EZN_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ewma_zscore_normalizer check failed");

// next-cycle implication
`define EZN_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ewma_zscore_normalizer check failed");

`endif

FILE: sv/ezn_pkg.sv
// Shared constants and controller/datapath interface types for the
// EWMA z-score normalizer. No dependencies.
package ezn_pkg;

   localparam int METRICS = 4;
   localparam int MIDX_W  = (METRICS > 1) ? $clog2(METRICS) : 1;

   localparam logic [16:0] Q16_ONE     = 17'd65536;
   localparam logic [12:0] TENTH_Q16   = 13'd6554;
   localparam logic [15:0] SCORE_LIMIT = 16'd24576;

   localparam int CNT_W = 5;
   localparam logic [CNT_W-1:0] SQRT_LAST = 5'd31;  // 32 root bits
   localparam logic [CNT_W-1:0] DIV_LAST  = 5'd14;  // 15 quotient bits

   localparam logic [1:0] REG_ALPHA = 2'd0;
   localparam logic [1:0] REG_FLOOR = 2'd1;
   localparam logic [1:0] REG_NEG   = 2'd2;

   typedef struct packed {
      logic idle;
      logic capture;
      logic load;
      logic sqrt_step;
      logic div_init;
      logic div_step;
      logic mul1;
      logic mul2;
      logic mul3;
      logic seed1;
      logic seed2;
      logic finish;
   } ezn_cmd_type;

   typedef struct packed {
      logic primed;
      logic idx_ok;
      logic out_free;
   } ezn_status_type;

endpackage

FILE: sv/ezn_ctrl.sv
// Sequencer for the EWMA z-score normalizer: steps the datapath through
// load, root, divide, update or seed, and result phases. Depends on ezn_pkg.
module ezn_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  ezn_pkg::ezn_status_type status,
   output ezn_pkg::ezn_cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_LOAD   = 4'd1;
   localparam logic [3:0] ST_SQRT   = 4'd2;
   localparam logic [3:0] ST_DIVCHK = 4'd3;
   localparam logic [3:0] ST_DIV    = 4'd4;
   localparam logic [3:0] ST_MUL1   = 4'd5;
   localparam logic [3:0] ST_MUL2   = 4'd6;
   localparam logic [3:0] ST_MUL3   = 4'd7;
   localparam logic [3:0] ST_SEED1  = 4'd8;
   localparam logic [3:0] ST_SEED2  = 4'd9;
   localparam logic [3:0] ST_FINISH = 4'd10;

   logic [3:0]                state_ff, state_in;
   logic [ezn_pkg::CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.idle = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            priority if (!status.primed) state_in = ST_SEED1;
            else if (!status.idx_ok)     state_in = ST_FINISH;
            else                         state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == ezn_pkg::SQRT_LAST) state_in = ST_DIVCHK;
         end
         ST_DIVCHK: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == ezn_pkg::DIV_LAST) state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.mul3 = 1'b1;
            state_in = ST_FINISH;
         end
         ST_SEED1: begin
            cmd.seed1 = 1'b1;
            state_in  = ST_SEED2;
         end
         ST_SEED2: begin
            cmd.seed2 = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register can take the result
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

FILE: sv/ezn_datapath.sv
// Datapath of the EWMA z-score normalizer: per-metric mean/variance store,
// bit-serial root and divide, update multipliers, output register.
// Depends on ezn_pkg.
module ezn_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  ezn_pkg::ezn_cmd_type    cmd,
   output ezn_pkg::ezn_status_type status,
   input  logic [16:0]             alpha,
   input  logic [16:0]             eps,
   input  logic [3:0]              neg_metric,
   input  logic [3:0]              req_metric_index,
   input  logic signed [31:0]      req_sample,
   input  logic                    req_vector_end,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic [3:0]              rsp_result_index,
   output logic signed [15:0]      rsp_score,
   output logic                    rsp_primed,
   output logic                    rsp_result_end
);

   localparam logic [47:0] VAR_MAX = {48{1'b1}};

   // item and store
   logic [3:0]         idx_ff;
   logic signed [31:0] x_ff;
   logic               vend_ff;
   logic               seeded_ff;
   logic signed [31:0] mean_ff [ezn_pkg::METRICS];
   logic [47:0]        var_ff  [ezn_pkg::METRICS];

   // working registers
   logic signed [31:0] m_ff;
   logic [47:0]        v_ff;
   logic               dneg_ff;
   logic [31:0]        mag_ff;
   logic [63:0]        rad_ff;
   logic [34:0]        rem_ff;
   logic [31:0]        root_ff;
   logic [43:0]        drem_ff;
   logic [45:0]        dvs_ff;
   logic [14:0]        q_ff;
   logic               over_ff;
   logic [32:0]        step_ff;
   logic [47:0]        d2_ff;
   logic [49:0]        t_ff;
   logic signed [31:0] nm_ff;
   logic [47:0]        nv_ff;
   logic [28:0]        scale_ff;
   logic [47:0]        sv_ff;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         rsp_idx_ff;
   logic signed [15:0] rsp_score_ff;
   logic               rsp_primed_ff;
   logic               rsp_end_ff;

   logic                      idx_ok;
   logic [ezn_pkg::MIDX_W-1:0] aidx;
   logic signed [32:0]        delta;
   logic [48:0]               rad_sum;
   logic [34:0]               rem_sh, trial;
   logic                      sq_ge;
   logic [43:0]               num;
   logic                      dv_ge;
   logic [48:0]               p_step;
   logic [63:0]               p_sq;
   logic [64:0]               p_a;
   logic [66:0]               p_b;
   logic [16:0]               beta;
   logic [50:0]               nv_raw;
   logic signed [33:0]        nm_raw;
   logic [31:0]               ax;
   logic [44:0]               p_sd;
   logic [28:0]               sc_raw;
   logic [57:0]               p_sv;
   logic [15:0]               zq;
   logic                      flip;
   logic signed [15:0]        score;

   assign idx_ok = ({1'b0, idx_ff} < 5'(ezn_pkg::METRICS));
   assign aidx   = idx_ff[ezn_pkg::MIDX_W-1:0];

   assign status.primed   = seeded_ff;
   assign status.idx_ok   = idx_ok;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      delta   = {x_ff[31], x_ff} - {mean_ff[aidx][31], mean_ff[aidx]};
      rad_sum = {1'b0, var_ff[aidx]} + {32'b0, eps};

      // root: two radicand bits per step
      rem_sh = {rem_ff[32:0], rad_ff[63:62]};
      trial  = {1'b0, root_ff, 2'b01};
      sq_ge  = (rem_sh >= trial);

      // rounded quotient numerator |delta|*2^11 + R/2
      num   = {1'b0, mag_ff, 11'b0} + {13'b0, root_ff[31:1]};
      dv_ge = ({2'b0, drem_ff} >= dvs_ff);

      p_step = 49'(mag_ff) * 49'(alpha);
      p_sq   = 64'(mag_ff) * 64'(mag_ff);
      p_a    = 65'(d2_ff) * 65'(alpha);
      beta   = ezn_pkg::Q16_ONE - alpha;
      p_b    = 67'(t_ff) * 67'(beta);
      nv_raw = 51'((p_b + 67'd32768) >> 16);
      nm_raw = dneg_ff ? ({{2{m_ff[31]}}, m_ff} - {1'b0, step_ff})
                       : ({{2{m_ff[31]}}, m_ff} + {1'b0, step_ff});

      ax     = x_ff[31] ? (32'd0 - x_ff) : x_ff;
      p_sd   = 45'(ax) * 45'(ezn_pkg::TENTH_Q16);
      sc_raw = 29'((p_sd + 45'd32768) >> 16);
      p_sv   = 58'(scale_ff) * 58'(scale_ff);

      if (over_ff || ({1'b0, q_ff} > ezn_pkg::SCORE_LIMIT)) zq = ezn_pkg::SCORE_LIMIT;
      else                                                  zq = {1'b0, q_ff};
      flip = dneg_ff ^ (idx_ff == neg_metric);
      if (!seeded_ff || !idx_ok) score = '0;
      else if (flip)             score = 16'sd0 - $signed(zq);
      else                       score = $signed(zq);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff  <= req_metric_index;
         x_ff    <= req_sample;
         vend_ff <= req_vector_end;
      end
      if (cmd.load) begin
         m_ff    <= mean_ff[aidx];
         v_ff    <= var_ff[aidx];
         dneg_ff <= delta[32];
         mag_ff  <= delta[32] ? 32'(33'd0 - delta) : delta[31:0];
         rad_ff  <= {1'b0, rad_sum, 14'b0};
         rem_ff  <= '0;
         root_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         rad_ff  <= rad_ff << 2;
         rem_ff  <= sq_ge ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[30:0], sq_ge};
      end
      if (cmd.div_init) begin
         drem_ff <= num;
         dvs_ff  <= {root_ff, 14'b0};
         over_ff <= ({3'b0, num} >= {root_ff, 15'b0});
         q_ff    <= '0;
      end
      if (cmd.div_step) begin
         if (dv_ge) drem_ff <= drem_ff - dvs_ff[43:0];
         dvs_ff <= dvs_ff >> 1;
         q_ff   <= {q_ff[13:0], dv_ge};
      end
      if (cmd.mul1) begin
         step_ff <= 33'((p_step + 49'd32768) >> 16);
         d2_ff   <= 48'((p_sq + 64'd32768) >> 16);
      end
      if (cmd.mul2) begin
         t_ff <= 50'(v_ff) + 50'((p_a + 65'd32768) >> 16);
      end
      if (cmd.mul3) begin
         priority if (nv_raw < 51'(eps))    nv_ff <= 48'(eps);
         else if (nv_raw > 51'(VAR_MAX))    nv_ff <= VAR_MAX;
         else                               nv_ff <= nv_raw[47:0];
         priority if (nm_raw > 34'sh07FFFFFFF)       nm_ff <= 32'sh7FFFFFFF;
         else if (nm_raw < -34'sh080000000)          nm_ff <= 32'sh80000000;
         else                                         nm_ff <= nm_raw[31:0];
      end
      if (cmd.seed1) begin
         scale_ff <= (sc_raw < 29'(ezn_pkg::Q16_ONE)) ? 29'(ezn_pkg::Q16_ONE) : sc_raw;
      end
      if (cmd.seed2) begin
         sv_ff <= 48'((p_sv + 58'd32768) >> 16);
      end
      if (cmd.finish) begin
         rsp_idx_ff    <= idx_ff;
         rsp_score_ff  <= score;
         rsp_primed_ff <= seeded_ff;
         rsp_end_ff    <= vend_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish)              rsp_valid_in = 1'b1;
      else if (!rsp_stall)         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ezn_pkg::METRICS; i++) begin
            mean_ff[i] <= '0;
            var_ff[i]  <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.finish) begin
            if (!seeded_ff) begin
               if (idx_ok) begin
                  mean_ff[aidx] <= x_ff;
                  var_ff[aidx]  <= sv_ff;
               end
               if (vend_ff) seeded_ff <= 1'b1;
            end else if (idx_ok) begin
               mean_ff[aidx] <= nm_ff;
               var_ff[aidx]  <= nv_ff;
            end
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_idx_ff;
   assign rsp_score        = rsp_score_ff;
   assign rsp_primed       = rsp_primed_ff;
   assign rsp_result_end   = rsp_end_ff;

endmodule

FILE: sv/ewma_zscore_normalizer_top.sv
// EWMA z-score normalizer top level: register file, sequencer, datapath.
// Depends on ezn_pkg, ezn_ctrl, ezn_datapath.
//
// One sample per request transfer (metric index, Q16.16 sample, vector end);
// one response transfer per sample carrying the Q3.12 score, the primed flag
// and the echoed index and vector end. Until the first vector ends, samples
// seed their metric and score zero.
// A scored sample passes through the bit-serial square root, the restoring
// divide and three multiply steps; a seeding sample passes through the seed
// steps, and an out-of-range index after priming goes from load to result.
// One sample in work at a time.
// req_stall is low only while the sequencer is idle; a finished result sits
// in the output register, so the next sample is taken while it waits.
// If rsp_stall holds a result and the next one finishes, that one waits in
// the sequencer until the output register frees.
// Synchronous reset clears means, variances, the seeded flag and the
// registers to their defaults (alpha 6554, floor 66, negated metric 0).
// Registers sit at byte addresses 0, 4, 8 of the APB-style port; write only
// while idle.
module ewma_zscore_normalizer_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_metric_index,
   input  logic signed [31:0] req_sample,
   input  logic               req_vector_end,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_result_index,
   output logic signed [15:0] rsp_score,
   output logic               rsp_primed,
   output logic               rsp_result_end,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [16:0] alpha_ff;
   logic [16:0] floor_ff;
   logic [3:0]  neg_ff;
   logic [16:0] alpha;
   logic [16:0] eps;
   logic        wr;

   ezn_pkg::ezn_cmd_type    cmd;
   ezn_pkg::ezn_status_type status;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= 17'd6554;
         floor_ff <= 17'd66;
         neg_ff   <= 4'd0;
      end else if (wr) begin
         unique case (paddr[3:2])
            ezn_pkg::REG_ALPHA: alpha_ff <= pwdata[16:0];
            ezn_pkg::REG_FLOOR: floor_ff <= pwdata[16:0];
            ezn_pkg::REG_NEG:   neg_ff   <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         ezn_pkg::REG_ALPHA: prdata = {15'b0, alpha_ff};
         ezn_pkg::REG_FLOOR: prdata = {15'b0, floor_ff};
         ezn_pkg::REG_NEG:   prdata = {28'b0, neg_ff};
         default:            prdata = '0;
      endcase
   end

   // weight above one acts as one; a zero floor acts as one lsb
   assign alpha = (alpha_ff > ezn_pkg::Q16_ONE) ? ezn_pkg::Q16_ONE : alpha_ff;
   assign eps   = (floor_ff == 17'd0) ? 17'd1 : floor_ff;

   assign req_stall = !cmd.idle;

   ezn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd)
   );

   ezn_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .alpha            (alpha),
      .eps              (eps),
      .neg_metric       (neg_ff),
      .req_metric_index (req_metric_index),
      .req_sample       (req_sample),
      .req_vector_end   (req_vector_end),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_result_index (rsp_result_index),
      .rsp_score        (rsp_score),
      .rsp_primed       (rsp_primed),
      .rsp_result_end   (rsp_result_end)
   );

endmodule

FILE: sv/ezn_checker.sv
// Port-level checks for the EWMA z-score normalizer, bound to the top level.
// Depends on ewma_zscore_normalizer_top_macros.svh.
`include "ewma_zscore_normalizer_top_macros.svh"

module ezn_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_score,
   input logic               rsp_primed
);

   // a stalled response stays up
   `EZN_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // the block is busy right after a request transfer
   `EZN_ASSERT_NXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall)
   // seeding results carry a zero score
   `EZN_ASSERT_IMP(a_seed_zero, clock, reset, rsp_valid && !rsp_primed, rsp_score == 16'sd0)
   // nothing is presented right after reset
   `EZN_ASSERT_NXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid)

endmodule

bind ewma_zscore_normalizer_top ezn_checker u_ezn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_score  (rsp_score),
   .rsp_primed (rsp_primed)
);
